### hw/rtl/ewe_pkg.sv
// Shared constants, codes and types of the editable wavetable engine.
package ewe_pkg;

  localparam int TABLE_DEPTH_DEF = 512;
  localparam int LEN_W   = 10;
  localparam int VS_W    = 3;
  localparam int RAD_W   = 7;
  localparam int REQ_W   = 3;
  localparam int X_W     = 9;
  localparam int Y_W     = 8;
  localparam int CFG_W   = 10;
  localparam int CFG_IW  = 2;
  localparam int FRAC_W  = 16;
  localparam int QUO_W   = 24;
  localparam int DEN_W   = 9;
  localparam int M_W     = 25;
  localparam int MX_W    = 10;
  localparam int PROD_W  = 40;
  localparam int B_W     = PROD_W - FRAC_W;
  localparam int DRAG_RECIP = 205;
  localparam int DRAG_RSH   = 10;

  localparam logic [Y_W-1:0]    NEUTRAL_LEVEL = 8'h80;
  localparam logic [LEN_W-1:0]  LEN_RESET     = 10'd500;
  localparam logic [VS_W-1:0]   VS_RESET      = 3'd1;
  localparam logic [RAD_W-1:0]  RAD_RESET     = 7'd20;

  localparam logic [CFG_IW-1:0] CFG_TABLE_LENGTH = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_VOLUME_SHIFT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DRAG_RADIUS  = 2'd2;

  localparam logic [REQ_W-1:0] REQ_PLAY   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SMOOTH = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STROKE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DRAG   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_PLAY_RD,
    S_PLAY_OUT,
    S_SM_RDL,
    S_SM_RD1,
    S_SM_ZERO,
    S_SM_RUN,
    S_SM_LAST,
    S_ST_CHK,
    S_ST_DIV,
    S_ST_MB,
    S_ST_B,
    S_ST_RUN,
    S_ST_FLUSH,
    S_ST_END,
    S_DR_RUN,
    S_DR_LAST
  } state_t;

endpackage

### hw/rtl/ewe_table.sv
// Wave level memory: one write port, one registered read port.
module ewe_table #(
  parameter int DEPTH = ewe_pkg::TABLE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [ewe_pkg::Y_W-1:0]  wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [ewe_pkg::Y_W-1:0]  rdata
);

  logic [ewe_pkg::Y_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ewe_div.sv
// Restoring divider for the stroke slope, one quotient bit per cycle.
module ewe_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ewe_pkg::QUO_W-1:0] num,
  input  logic [ewe_pkg::DEN_W-1:0] den,
  output logic                      done,
  output logic [ewe_pkg::QUO_W-1:0] quot
);

  localparam int CNT_W = $clog2(ewe_pkg::QUO_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic [ewe_pkg::DEN_W-1:0] rem;
  logic [ewe_pkg::DEN_W-1:0] den_r;
  logic [ewe_pkg::QUO_W-1:0] qr;
  logic [ewe_pkg::DEN_W:0]   rem2;
  logic                      ge;
  logic [ewe_pkg::DEN_W:0]   diff;

  always_comb begin
    rem2 = {rem, qr[ewe_pkg::QUO_W-1]};
    ge   = rem2 >= {1'b0, den_r};
    diff = rem2 - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem   <= '0;
        qr    <= num;
        den_r <= den;
      end else if (busy) begin
        rem <= ge ? diff[ewe_pkg::DEN_W-1:0] : rem2[ewe_pkg::DEN_W-1:0];
        qr  <= {qr[ewe_pkg::QUO_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(ewe_pkg::QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = qr;

endmodule

### hw/rtl/ewe_alu.sv
// Shared arithmetic: registered line multiplier, neighbor average, drag step, line clamp.
module ewe_alu (
  input  logic                              clk,
  input  logic signed [ewe_pkg::M_W-1:0]    mul_a,
  input  logic [ewe_pkg::X_W-1:0]           mul_x,
  input  logic signed [ewe_pkg::B_W-1:0]    b_term,
  input  logic [ewe_pkg::Y_W-1:0]           avg_a,
  input  logic [ewe_pkg::Y_W-1:0]           avg_b,
  input  logic [ewe_pkg::Y_W-1:0]           drag_d,
  input  logic [ewe_pkg::Y_W-1:0]           drag_y,
  output logic signed [ewe_pkg::PROD_W-1:0] prod,
  output logic [ewe_pkg::Y_W-1:0]           avg_o,
  output logic [ewe_pkg::Y_W-1:0]           drag_o,
  output logic [ewe_pkg::Y_W-1:0]           line_o
);

  localparam int YW = ewe_pkg::Y_W;
  localparam int PW = ewe_pkg::PROD_W;
  localparam int FW = ewe_pkg::FRAC_W;

  logic signed [ewe_pkg::MX_W-1:0]          mul_b;
  logic signed [ewe_pkg::M_W+ewe_pkg::MX_W-1:0] prod_raw;
  logic [YW:0]                              sum_a;
  logic [YW:0]                              sum_d;
  logic signed [YW:0]                       delta;
  logic [YW-1:0]                            mag;
  logic [2*YW-1:0]                          scaled;
  logic [YW-1:0]                            fifth;
  logic signed [PW-1:0]                     q;

  always_comb begin
    mul_b    = $signed({1'b0, mul_x});
    prod_raw = mul_a * mul_b;

    sum_a = {1'b0, avg_a} + {1'b0, avg_b};
    avg_o = sum_a[YW:1];

    sum_d  = {1'b0, drag_d} + {1'b0, drag_y};
    delta  = $signed({1'b0, drag_d}) - $signed({1'b0, sum_d[YW:1]});
    mag    = delta[YW] ? YW'(-delta) : delta[YW-1:0];
    scaled = mag * (2*YW)'(ewe_pkg::DRAG_RECIP);
    fifth  = YW'(scaled >> ewe_pkg::DRAG_RSH);
    drag_o = delta[YW] ? drag_d + fifth : drag_d - fifth;

    q = prod + $signed({b_term, {FW{1'b0}}});
    if (q[PW-1]) begin
      line_o = '0;
    end else if (|q[PW-1:FW+YW]) begin
      line_o = '1;
    end else begin
      line_o = q[FW+YW-1:FW];
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(prod_raw);
  end

endmodule

### hw/rtl/editable_wavetable_engine.sv
// Top level of the editable wavetable engine: sequencer, state and config registers.
//
//   channel | words                                  | handshake
//   in      | req_type, pos_x, level_y, new_stroke   | in_valid / in_stall
//   out     | sample (play ticks only)               | out_valid / out_stall
//   cfg     | cfg_index, cfg_data                    | cfg_we
//
// Play tick: a table read, then the output, which waits on out_stall. Smooth: one pass over the table.
// Stroke: a line from the previous point if its x differs; else only the end point.
// Drag: one pass over the window. Clear: a sweep of the table, one entry per cycle.
// After rst the table is swept to neutral with in_stall high.
// in_stall is low only when the sequencer is idle; a held sample blocks only the next play.
module editable_wavetable_engine #(
  parameter int TABLE_DEPTH = ewe_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ewe_pkg::REQ_W-1:0]   req_type,
  input  logic [ewe_pkg::X_W-1:0]     pos_x,
  input  logic [ewe_pkg::Y_W-1:0]     level_y,
  input  logic                        new_stroke,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ewe_pkg::Y_W-1:0]     sample,
  input  logic                        cfg_we,
  input  logic [ewe_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [ewe_pkg::CFG_W-1:0]   cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = AW + 1;
  localparam int CW = (NW > ewe_pkg::LEN_W) ? NW : ewe_pkg::LEN_W;
  localparam int XW = ewe_pkg::X_W;
  localparam int YW = ewe_pkg::Y_W;

  function automatic logic [AW-1:0] xa(input logic [XW-1:0] v);
    logic [AW+XW-1:0] e;
    e = {{AW{1'b0}}, v};
    return e[AW-1:0];
  endfunction

  ewe_pkg::state_t state, state_next;

  logic [ewe_pkg::LEN_W-1:0] table_length;
  logic [ewe_pkg::VS_W-1:0]  volume_shift;
  logic [ewe_pkg::RAD_W-1:0] drag_radius;

  logic [NW-1:0]  cnt;
  logic [NW-1:0]  hi;
  logic [XW-1:0]  xr;
  logic [YW-1:0]  yr;
  logic [YW-1:0]  hold;
  logic [YW-1:0]  left;
  logic [YW-1:0]  first;
  logic [AW-1:0]  play_pos;
  logic           prev_valid;
  logic [XW-1:0]  prev_x;
  logic [YW-1:0]  prev_y;
  logic           neg;
  logic           up;
  logic [XW-1:0]  xp;
  logic           pv;
  logic [AW-1:0]  paddr;
  logic signed [ewe_pkg::M_W-1:0] m;
  logic signed [ewe_pkg::B_W-1:0] b;

  logic [CW-1:0]  len_c;
  logic [CW-1:0]  n_c;
  logic [CW-1:0]  nm1_c;
  logic [NW-1:0]  n;
  logic [XW-1:0]  x_cl;
  logic [NW-1:0]  pn;
  logic [AW-1:0]  pnext;
  logic [XW-1:0]  lo;
  logic [ewe_pkg::LEN_W-1:0] hi_sum;
  logic [CW-1:0]  hi_c;
  logic           acc;
  logic           can_out;
  logic [XW-1:0]  xp_next;

  logic signed [XW:0]   dx;
  logic signed [YW:0]   dy;
  logic [ewe_pkg::DEN_W-1:0] adx;
  logic [YW-1:0]        ady;
  logic signed [ewe_pkg::PROD_W-1:0] p_b;
  logic signed [ewe_pkg::B_W-1:0]    b_val;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [YW-1:0]  mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [YW-1:0]  rdata;

  logic           div_start;
  logic           div_done;
  logic [ewe_pkg::QUO_W-1:0] quot;

  logic [XW-1:0]  mul_x;
  logic [YW-1:0]  avg_a;
  logic [YW-1:0]  avg_b;
  logic signed [ewe_pkg::PROD_W-1:0] prod;
  logic [YW-1:0]  avg_o;
  logic [YW-1:0]  drag_o;
  logic [YW-1:0]  line_o;

  ewe_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  ewe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({ady, {ewe_pkg::FRAC_W{1'b0}}}),
    .den   (adx),
    .done  (div_done),
    .quot  (quot)
  );

  ewe_alu u_alu (
    .clk    (clk),
    .mul_a  (m),
    .mul_x  (mul_x),
    .b_term (b),
    .avg_a  (avg_a),
    .avg_b  (avg_b),
    .drag_d (rdata),
    .drag_y (yr),
    .prod   (prod),
    .avg_o  (avg_o),
    .drag_o (drag_o),
    .line_o (line_o)
  );

  always_comb begin
    len_c = CW'(table_length);
    if (len_c < CW'(3)) begin
      n_c = CW'(3);
    end else if (len_c > CW'(TABLE_DEPTH)) begin
      n_c = CW'(TABLE_DEPTH);
    end else begin
      n_c = len_c;
    end
    nm1_c = n_c - 1'b1;
    n     = n_c[NW-1:0];
    x_cl  = (CW'(pos_x) > nm1_c) ? nm1_c[XW-1:0] : pos_x;

    pn    = {1'b0, play_pos} + 1'b1;
    pnext = (pn >= n) ? '0 : pn[AW-1:0];

    lo     = (x_cl >= XW'(drag_radius)) ? x_cl - XW'(drag_radius) : '0;
    hi_sum = {1'b0, x_cl} + ewe_pkg::LEN_W'(drag_radius);
    hi_c   = (CW'(hi_sum) > n_c) ? n_c : CW'(hi_sum);

    acc     = in_valid && (state == ewe_pkg::S_IDLE);
    can_out = !out_valid || !out_stall;
    xp_next = up ? xp + 1'b1 : xp - 1'b1;

    dx  = $signed({1'b0, prev_x}) - $signed({1'b0, xr});
    dy  = $signed({1'b0, prev_y}) - $signed({1'b0, yr});
    adx = dx[XW] ? ewe_pkg::DEN_W'(-dx) : dx[XW-1:0];
    ady = dy[YW] ? YW'(-dy) : dy[YW-1:0];

    p_b   = $signed({{(ewe_pkg::PROD_W-ewe_pkg::FRAC_W-YW){1'b0}}, yr,
                     {ewe_pkg::FRAC_W{1'b0}}}) - prod;
    b_val = p_b[ewe_pkg::PROD_W-1:ewe_pkg::FRAC_W] +
            ewe_pkg::B_W'(p_b[ewe_pkg::PROD_W-1] && (p_b[ewe_pkg::FRAC_W-1:0] != '0));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ewe_pkg::S_CLR: begin
        if (cnt == NW'(TABLE_DEPTH - 1)) state_next = ewe_pkg::S_IDLE;
      end
      ewe_pkg::S_IDLE: begin
        if (acc) begin
          unique case (req_type)
            ewe_pkg::REQ_PLAY:   state_next = ewe_pkg::S_PLAY_RD;
            ewe_pkg::REQ_SMOOTH: state_next = ewe_pkg::S_SM_RDL;
            ewe_pkg::REQ_STROKE: state_next = ewe_pkg::S_ST_CHK;
            ewe_pkg::REQ_DRAG: begin
              if (CW'(lo) < hi_c) state_next = ewe_pkg::S_DR_RUN;
            end
            ewe_pkg::REQ_CLEAR:  state_next = ewe_pkg::S_CLR;
            default:             state_next = ewe_pkg::S_IDLE;
          endcase
        end
      end
      ewe_pkg::S_PLAY_RD:  state_next = ewe_pkg::S_PLAY_OUT;
      ewe_pkg::S_PLAY_OUT: begin
        if (can_out) state_next = ewe_pkg::S_IDLE;
      end
      ewe_pkg::S_SM_RDL:   state_next = ewe_pkg::S_SM_RD1;
      ewe_pkg::S_SM_RD1:   state_next = ewe_pkg::S_SM_ZERO;
      ewe_pkg::S_SM_ZERO:  state_next = ewe_pkg::S_SM_RUN;
      ewe_pkg::S_SM_RUN: begin
        if (cnt == n - NW'(2)) state_next = ewe_pkg::S_SM_LAST;
      end
      ewe_pkg::S_SM_LAST:  state_next = ewe_pkg::S_IDLE;
      ewe_pkg::S_ST_CHK: begin
        state_next = (prev_valid && (prev_x != xr)) ? ewe_pkg::S_ST_DIV : ewe_pkg::S_ST_END;
      end
      ewe_pkg::S_ST_DIV: begin
        if (div_done) state_next = ewe_pkg::S_ST_MB;
      end
      ewe_pkg::S_ST_MB:    state_next = ewe_pkg::S_ST_B;
      ewe_pkg::S_ST_B:     state_next = ewe_pkg::S_ST_RUN;
      ewe_pkg::S_ST_RUN: begin
        if (xp_next == xr) state_next = ewe_pkg::S_ST_FLUSH;
      end
      ewe_pkg::S_ST_FLUSH: state_next = ewe_pkg::S_ST_END;
      ewe_pkg::S_ST_END:   state_next = ewe_pkg::S_IDLE;
      ewe_pkg::S_DR_RUN: begin
        if (cnt == hi - 1'b1) state_next = ewe_pkg::S_DR_LAST;
      end
      ewe_pkg::S_DR_LAST:  state_next = ewe_pkg::S_IDLE;
      default:             state_next = ewe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ewe_pkg::S_IDLE);
    mem_we    = 1'b0;
    mem_waddr = cnt[AW-1:0];
    mem_wdata = avg_o;
    mem_re    = 1'b0;
    mem_raddr = cnt[AW-1:0];
    div_start = 1'b0;
    mul_x     = xp;
    avg_a     = left;
    avg_b     = rdata;
    unique case (state)
      ewe_pkg::S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = ewe_pkg::NEUTRAL_LEVEL;
      end
      ewe_pkg::S_PLAY_RD: begin
        mem_re    = 1'b1;
        mem_raddr = play_pos;
      end
      ewe_pkg::S_SM_RDL: begin
        mem_re    = 1'b1;
        mem_raddr = nm1_c[AW-1:0];
      end
      ewe_pkg::S_SM_RD1: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      ewe_pkg::S_SM_ZERO: begin
        avg_a     = rdata;
        avg_b     = hold;
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_re    = 1'b1;
        mem_raddr = AW'(2);
      end
      ewe_pkg::S_SM_RUN: begin
        mem_we    = 1'b1;
        mem_re    = 1'b1;
        mem_raddr = AW'(cnt + NW'(2));
      end
      ewe_pkg::S_SM_LAST: begin
        avg_a     = first;
        avg_b     = left;
        mem_we    = 1'b1;
        mem_waddr = nm1_c[AW-1:0];
      end
      ewe_pkg::S_ST_CHK: begin
        div_start = prev_valid && (prev_x != xr);
      end
      ewe_pkg::S_ST_MB: begin
        mul_x = xr;
      end
      ewe_pkg::S_ST_RUN: begin
        mem_we    = pv;
        mem_waddr = paddr;
        mem_wdata = line_o;
      end
      ewe_pkg::S_ST_FLUSH: begin
        mem_we    = 1'b1;
        mem_waddr = paddr;
        mem_wdata = line_o;
      end
      ewe_pkg::S_ST_END: begin
        mem_we    = 1'b1;
        mem_waddr = xa(xr);
        mem_wdata = yr;
      end
      ewe_pkg::S_DR_RUN: begin
        mem_re    = 1'b1;
        mem_we    = pv;
        mem_waddr = paddr;
        mem_wdata = drag_o;
      end
      ewe_pkg::S_DR_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = paddr;
        mem_wdata = drag_o;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= ewe_pkg::LEN_RESET;
      volume_shift <= ewe_pkg::VS_RESET;
      drag_radius  <= ewe_pkg::RAD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ewe_pkg::CFG_TABLE_LENGTH: table_length <= cfg_data[ewe_pkg::LEN_W-1:0];
        ewe_pkg::CFG_VOLUME_SHIFT: volume_shift <= cfg_data[ewe_pkg::VS_W-1:0];
        ewe_pkg::CFG_DRAG_RADIUS:  drag_radius  <= cfg_data[ewe_pkg::RAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ewe_pkg::S_CLR;
      cnt        <= '0;
      play_pos   <= '0;
      prev_valid <= 1'b0;
      prev_x     <= '0;
      prev_y     <= '0;
      pv         <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == ewe_pkg::S_PLAY_OUT) && can_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ewe_pkg::S_CLR: cnt <= cnt + 1'b1;
        ewe_pkg::S_IDLE: begin
          if (acc) begin
            xr <= x_cl;
            yr <= level_y;
            pv <= 1'b0;
            unique case (req_type)
              ewe_pkg::REQ_PLAY: play_pos <= pnext;
              ewe_pkg::REQ_STROKE: begin
                if (new_stroke) prev_valid <= 1'b0;
              end
              ewe_pkg::REQ_DRAG: begin
                cnt <= NW'(lo);
                hi  <= hi_c[NW-1:0];
              end
              ewe_pkg::REQ_CLEAR: cnt <= '0;
              default: begin
              end
            endcase
          end
        end
        ewe_pkg::S_PLAY_OUT: begin
          if (can_out) begin
            sample <= rdata >> volume_shift;
          end
        end
        ewe_pkg::S_SM_RD1: hold <= rdata;
        ewe_pkg::S_SM_ZERO: begin
          left  <= avg_o;
          first <= avg_o;
          cnt   <= NW'(1);
        end
        ewe_pkg::S_SM_RUN: begin
          left <= avg_o;
          cnt  <= cnt + 1'b1;
        end
        ewe_pkg::S_ST_CHK: begin
          neg <= dx[XW] ^ dy[YW];
          up  <= xr > prev_x;
          xp  <= prev_x;
        end
        ewe_pkg::S_ST_DIV: begin
          if (div_done) begin
            m <= neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
          end
        end
        ewe_pkg::S_ST_B: begin
          b  <= b_val;
          pv <= 1'b0;
        end
        ewe_pkg::S_ST_RUN: begin
          pv    <= 1'b1;
          paddr <= xa(xp);
          xp    <= xp_next;
        end
        ewe_pkg::S_ST_END: begin
          prev_x     <= xr;
          prev_y     <= yr;
          prev_valid <= 1'b1;
        end
        ewe_pkg::S_DR_RUN: begin
          pv    <= 1'b1;
          paddr <= cnt[AW-1:0];
          cnt   <= cnt + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ewe_pkg::S_IDLE) |-> !mem_we)
    else $error("table written while idle");

  a_out_from_play: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ewe_pkg::S_PLAY_OUT))
    else $error("sample raised outside a play tick");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ewe_pkg::S_ST_DIV))
    else $error("divider finished outside slope state");

  a_stroke_prev_set: assert property (@(posedge clk) disable iff (rst)
    (state == ewe_pkg::S_ST_END) |=> prev_valid)
    else $error("stroke point not recorded");

endmodule
